// File: rtl/deq_pkg.sv
// deq_pkg: shared types and constants for the double-ended queue
// holds operation and error codes, request/response beats and controller types
// no dependencies
`default_nettype none

package deq_pkg;

	// ring size, a power of two so ring indexes wrap by truncation
	localparam int DEPTH  = 16;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int WORD_W = 32;
	// count and capacity width, able to hold DEPTH itself
	localparam int CNT_W  = 5;

	typedef enum logic [1:0] {
		OP_PUSH_REAR  = 2'd0,
		OP_POP_FRONT  = 2'd1,
		OP_PUSH_FRONT = 2'd2,
		OP_POP_REAR   = 2'd3
	} op_e;

	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_FULL  = 2'd1;
	localparam logic [1:0] ERR_EMPTY = 2'd2;

	typedef struct packed {
		op_e                      op;
		logic signed [WORD_W-1:0] data_in;
	} req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] data_out;
		logic [1:0]               error_code;
		logic                     is_empty;
		logic                     is_full;
		logic [CNT_W-1:0]         item_total;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESP
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage

`default_nettype wire

// File: rtl/double_ended_queue_top.sv
// double_ended_queue_top: top level of the bounded double-ended queue
// depends on deq_pkg, deq_ctrl, deq_dp (which holds deq_ram)
//
// Usage:
//   Request channel: drive req (op, data_in) and raise start; the beat is
//   taken at a rising edge where start is high and busy is low.
//   Ops: push rear, pop front, push front, pop rear.
//   Response channel: done is high for exactly one cycle with rsp holding the
//   popped word (zero for pushes and errors), the error code (full on push,
//   empty on pop, state untouched) and empty/full/count after the operation.
//   The receiver cannot stall; rsp is valid only while done is high.
//   Sequence: the accepting edge captures the request, ST_EXEC then does
//   the ring access with pointer/count update, and done is high in ST_RESP
//   with the ring's registered read data. busy stays high while done is
//   high, so the next request is taken only back in ST_IDLE: an operation
//   must finish before another is taken, set by the three-state controller.
//   Config: cfg_data sets the capacity (zero acts as 1, above 16 acts as 16);
//   cfg_ready is always high; write only while busy is low.
//   Reset (arst_n low): queue empty, front index zero, capacity 16; ring
//   contents are not cleared and are only read once pushed.
`default_nettype none

module double_ended_queue_top
	import deq_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire req_t             req,
	output logic                  done,
	output rsp_t                  rsp,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CNT_W-1:0] cfg_data
);

	cmd_t cmd;

	// sequencing
	deq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// ring store and bookkeeping
	deq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// File: rtl/deq_ram.sv
// deq_ram: generic single-port RAM with registered read data
// no dependencies
`default_nettype none

module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/deq_ctrl.sv
// deq_ctrl: controller state machine for the double-ended queue
// depends on deq_pkg
`default_nettype none

module deq_ctrl
	import deq_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	output logic      done,
	output cmd_t      cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		busy     = 1'b1;
		done     = 1'b0;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = ST_RESP;
			end
			ST_RESP: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/deq_dp.sv
// deq_dp: datapath of the double-ended queue: ring store, front index, count
// depends on deq_pkg and deq_ram
`default_nettype none

module deq_dp
	import deq_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cmd_t             cmd,
	input  wire req_t             req,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CNT_W-1:0] cfg_data,
	output rsp_t                  rsp
);

	op_e                 op_q;
	logic [WORD_W-1:0]   din_q;
	logic [ADDR_W-1:0]   front_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    cap_q;
	logic [1:0]          err_q;
	logic                popped_q;

	logic [CNT_W-1:0]    eff_cap;
	logic                full;
	logic                empty;
	logic [ADDR_W-1:0]   cnt_lo;
	logic                ram_we;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_addr;
	logic [WORD_W-1:0]   ram_rdata;

	assign cfg_ready = 1'b1;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CNT_W'(DEPTH);
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	// zero acts as one, above the ring size acts as the ring size
	always_comb begin
		eff_cap = cap_q;
		if (cap_q == '0) begin
			eff_cap = CNT_W'(1);
		end else if (cap_q > CNT_W'(DEPTH)) begin
			eff_cap = CNT_W'(DEPTH);
		end
	end

	assign full   = (count_q >= eff_cap);
	assign empty  = (count_q == '0);
	assign cnt_lo = count_q[ADDR_W-1:0];

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req.op;
			din_q <= req.data_in;
		end
	end

	// ring address and access for the operation at hand
	always_comb begin
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		ram_addr = front_q;
		case (op_q)
			OP_PUSH_REAR: begin
				ram_addr = front_q + cnt_lo;
				ram_we   = cmd.exec && !full;
			end
			OP_PUSH_FRONT: begin
				ram_addr = front_q - ADDR_W'(1);
				ram_we   = cmd.exec && !full;
			end
			OP_POP_FRONT: begin
				ram_addr = front_q;
				ram_re   = cmd.exec && !empty;
			end
			OP_POP_REAR: begin
				ram_addr = front_q + cnt_lo - ADDR_W'(1);
				ram_re   = cmd.exec && !empty;
			end
			default: begin
				ram_addr = front_q;
			end
		endcase
	end

	// front index, count and error update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			count_q  <= '0;
			err_q    <= ERR_OK;
			popped_q <= 1'b0;
		end else if (cmd.exec) begin
			err_q    <= ERR_OK;
			popped_q <= 1'b0;
			case (op_q)
				OP_PUSH_REAR: begin
					if (full) begin
						err_q <= ERR_FULL;
					end else begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				OP_PUSH_FRONT: begin
					if (full) begin
						err_q <= ERR_FULL;
					end else begin
						front_q <= front_q - ADDR_W'(1);
						count_q <= count_q + CNT_W'(1);
					end
				end
				OP_POP_FRONT: begin
					if (empty) begin
						err_q <= ERR_EMPTY;
					end else begin
						front_q  <= front_q + ADDR_W'(1);
						count_q  <= count_q - CNT_W'(1);
						popped_q <= 1'b1;
					end
				end
				OP_POP_REAR: begin
					if (empty) begin
						err_q <= ERR_EMPTY;
					end else begin
						count_q  <= count_q - CNT_W'(1);
						popped_q <= 1'b1;
					end
				end
				default: begin
					err_q <= ERR_OK;
				end
			endcase
		end
	end

	deq_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (din_q),
		.rdata (ram_rdata)
	);

	// response beat fields
	always_comb begin
		rsp.data_out   = popped_q ? ram_rdata : '0;
		rsp.error_code = err_q;
		rsp.is_empty   = empty;
		rsp.is_full    = full;
		rsp.item_total = count_q;
	end

endmodule

`default_nettype wire
